// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AM_IMPLY(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define AM_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/pdws_pkg.sv =====
// ---------------------------------------------------------------------------
// pdws_pkg
// Widths and limits shared by the PWM divider solver and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package pdws_pkg;

	localparam int CLK_W   = 32;
	localparam int FRQ_W   = 32;
	localparam int TOP_W   = 16;
	localparam int WHOLE_W = 8;
	localparam int FRAC_W  = 4;
	localparam int ACH_W   = 40;

	// Period can reach 65536, so it needs one bit more than the counter top.
	localparam int PER_W   = TOP_W + 1;
	// Divider in sixteenths.
	localparam int D16_W   = WHOLE_W + FRAC_W;

	localparam logic [PER_W-1:0] PERIOD_MAX = PER_W'(1) << TOP_W;
	localparam logic [D16_W-1:0] D16_MIN    = D16_W'(16);

endpackage

`default_nettype wire

// ===== design/pdws_div.sv =====
// ---------------------------------------------------------------------------
// pdws_div
// Pipelined restoring divider: one quotient bit per register stage, with a
// sideband word and a valid bit that travel alongside. The dividend must be
// below den * 2^QW for the quotient to be exact.
// ---------------------------------------------------------------------------
`default_nettype none

module pdws_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_vld,
	output logic [QW-1:0]      quot,
	output logic [SW-1:0]      side_out
);

	localparam int W = (NW > DW + QW) ? NW : DW + QW;

	logic [W-1:0]  rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];

	// Entry point of the chain.
	assign rem_s[0]  = W'(num);
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	// One compare and subtract per stage, most significant bit first.
	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int SH = QW - 1 - k;
		logic [W-1:0] trial;
		logic         take;

		assign trial = W'(den_s[k]) << SH;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				quo_s[k+1]  <= {quo_s[k][QW-2:0], take};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quot     = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

`default_nettype wire

// ===== design/pwm_divider_and_wrap_solver.sv =====
// ---------------------------------------------------------------------------
// pwm_divider_and_wrap_solver
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a result waits under out_stall.
// The three divisions (period, divider, achieved frequency) are bit-serial
// pipelines of 17, 12 and 40 stages.
// Reset clears only the valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module pwm_divider_and_wrap_solver
	import pdws_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [CLK_W-1:0]   source_clock,
	input  wire logic [FRQ_W-1:0]   wanted_freq,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    ok,
	output logic [TOP_W-1:0]        counter_top,
	output logic [WHOLE_W-1:0]      div_whole,
	output logic [FRAC_W-1:0]       div_sixteenths,
	output logic [ACH_W-1:0]        achieved_freq_q8
);

	localparam int DEN_W  = FRQ_W + PER_W;          // frq * period
	localparam int NUM2_W = DEN_W + 1;              // 32*clk + den, and 2*den
	localparam int FDN_W  = D16_W + PER_W;          // d16 * period
	localparam int NUM3_W = CLK_W + 14;             // 8192*clk + fden
	localparam int DV3_W  = FDN_W + 1;
	localparam int SIDE1_W = 2 + CLK_W + FRQ_W;
	localparam int SIDE2_W = 1 + PER_W + CLK_W;
	localparam int SIDE3_W = 1 + D16_W + PER_W;

	logic en;

	// The pipeline moves unless a finished result is held back.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Input stage: screen invalid requests and pick the period branch.
	logic             valid_s1, bad_s1, big_s1;
	logic [CLK_W-1:0] clk_s1;
	logic [FRQ_W-1:0] frq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clk_s1 <= source_clock;
			frq_s1 <= wanted_freq;
			bad_s1 <= (source_clock == '0) || (wanted_freq == '0) ||
				(wanted_freq > source_clock);
			big_s1 <= {TOP_W'(0), source_clock} > {wanted_freq, TOP_W'(0)};
		end
	end

	// Period division: clk / frq.
	logic               v_d1;
	logic [PER_W-1:0]   per_d1;
	logic [SIDE1_W-1:0] side_d1;

	pdws_div #(.NW(CLK_W), .DW(FRQ_W), .QW(PER_W), .SW(SIDE1_W)) u_div_per (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (valid_s1),
		.num      (clk_s1),
		.den      (frq_s1),
		.side_in  ({bad_s1, big_s1, clk_s1, frq_s1}),
		.out_vld  (v_d1),
		.quot     (per_d1),
		.side_out (side_d1)
	);

	logic             bad_d1, big_d1;
	logic [CLK_W-1:0] clk_d1;
	logic [FRQ_W-1:0] frq_d1;
	logic [PER_W-1:0] period_c;

	assign {bad_d1, big_d1, clk_d1, frq_d1} = side_d1;
	assign period_c = big_d1 ? PERIOD_MAX : per_d1;

	// Stage 2: divisor for the divider, frq * period.
	logic             valid_s2, bad_s2;
	logic [CLK_W-1:0] clk_s2;
	logic [PER_W-1:0] period_s2;
	logic [DEN_W-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s2    <= bad_d1;
			clk_s2    <= clk_d1;
			period_s2 <= period_c;
			den_s2    <= {PER_W'(0), frq_d1} * {FRQ_W'(0), period_c};
		end
	end

	// Stage 3: rounding numerator and the out-of-range test for the divider.
	logic [NUM2_W-1:0] num2_c, dv2_c;

	assign num2_c = {(NUM2_W - CLK_W - 5)'(0), clk_s2, 5'b0} + {1'b0, den_s2};
	assign dv2_c  = {den_s2, 1'b0};

	logic              valid_s3, inv_s3;
	logic [CLK_W-1:0]  clk_s3;
	logic [PER_W-1:0]  period_s3;
	logic [NUM2_W-1:0] num2_s3, dv2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s3    <= bad_s2 ||
				({D16_W'(0), num2_c} >= {dv2_c, D16_W'(0)});
			clk_s3    <= clk_s2;
			period_s3 <= period_s2;
			num2_s3   <= num2_c;
			dv2_s3    <= dv2_c;
		end
	end

	// Divider division: 16 * clk / den, rounded half up.
	logic               v_d2;
	logic [D16_W-1:0]   d16_d2;
	logic [SIDE2_W-1:0] side_d2;

	pdws_div #(.NW(NUM2_W), .DW(NUM2_W), .QW(D16_W), .SW(SIDE2_W)) u_div_d16 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (valid_s3),
		.num      (num2_s3),
		.den      (dv2_s3),
		.side_in  ({inv_s3, period_s3, clk_s3}),
		.out_vld  (v_d2),
		.quot     (d16_d2),
		.side_out (side_d2)
	);

	logic             inv_d2;
	logic [PER_W-1:0] period_d2;
	logic [CLK_W-1:0] clk_d2;

	assign {inv_d2, period_d2, clk_d2} = side_d2;

	// Stage 4: final validity and the achieved-frequency divisor.
	logic             valid_s4, inv_s4;
	logic [CLK_W-1:0] clk_s4;
	logic [PER_W-1:0] period_s4;
	logic [D16_W-1:0] d16_s4;
	logic [FDN_W-1:0] fden_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s4    <= inv_d2 || (d16_d2 < D16_MIN);
			clk_s4    <= clk_d2;
			period_s4 <= period_d2;
			d16_s4    <= d16_d2;
			fden_s4   <= {PER_W'(0), d16_d2} * {D16_W'(0), period_d2};
		end
	end

	// Stage 5: rounding numerator for the achieved frequency.
	logic              valid_s5, inv_s5;
	logic [PER_W-1:0]  period_s5;
	logic [D16_W-1:0]  d16_s5;
	logic [NUM3_W-1:0] num3_s5;
	logic [DV3_W-1:0]  dv3_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s5    <= inv_s4;
			period_s5 <= period_s4;
			d16_s5    <= d16_s4;
			num3_s5   <= {1'b0, clk_s4, 13'b0} + {(NUM3_W - FDN_W)'(0), fden_s4};
			dv3_s5    <= {fden_s4, 1'b0};
		end
	end

	// Achieved-frequency division: 4096 * clk / (d16 * period), rounded.
	logic               v_d3;
	logic [ACH_W-1:0]   ach_d3;
	logic [SIDE3_W-1:0] side_d3;

	pdws_div #(.NW(NUM3_W), .DW(DV3_W), .QW(ACH_W), .SW(SIDE3_W)) u_div_ach (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (valid_s5),
		.num      (num3_s5),
		.den      (dv3_s5),
		.side_in  ({inv_s5, d16_s5, period_s5}),
		.out_vld  (v_d3),
		.quot     (ach_d3),
		.side_out (side_d3)
	);

	logic             inv_d3;
	logic [D16_W-1:0] d16_d3;
	logic [PER_W-1:0] period_d3;
	logic [PER_W-1:0] top_c;

	assign {inv_d3, d16_d3, period_d3} = side_d3;
	assign top_c = period_d3 - PER_W'(1);

	// Output register: invalid requests give all-zero fields.
	logic               valid_q, ok_q;
	logic [TOP_W-1:0]   top_q;
	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [ACH_W-1:0]   ach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q    <= !inv_d3;
			top_q   <= inv_d3 ? '0 : top_c[TOP_W-1:0];
			whole_q <= inv_d3 ? '0 : d16_d3[D16_W-1:FRAC_W];
			frac_q  <= inv_d3 ? '0 : d16_d3[FRAC_W-1:0];
			ach_q   <= inv_d3 ? '0 : ach_d3;
		end
	end

	assign out_valid        = valid_q;
	assign ok               = ok_q;
	assign counter_top      = top_q;
	assign div_whole        = whole_q;
	assign div_sixteenths   = frac_q;
	assign achieved_freq_q8 = ach_q;

endmodule

`default_nettype wire

// ===== design/pdws_checker.sv =====
// ---------------------------------------------------------------------------
// pdws_checker
// Port-level checks on the PWM divider solver, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pdws_checker
	import pdws_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [CLK_W-1:0]   source_clock,
	input wire logic [FRQ_W-1:0]   wanted_freq,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               ok,
	input wire logic [TOP_W-1:0]   counter_top,
	input wire logic [WHOLE_W-1:0] div_whole,
	input wire logic [FRAC_W-1:0]  div_sixteenths,
	input wire logic [ACH_W-1:0]   achieved_freq_q8
);

	logic fields_zero;

	// All payload fields other than ok are zero.
	assign fields_zero = (counter_top == '0) && (div_whole == '0) &&
		(div_sixteenths == '0) && (achieved_freq_q8 == '0);

	// A held result beat stays offered.
	`AM_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// The input side stalls exactly when a result is held back.
	`AM_IMPLY(a_stall_link, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall))

	// A rejected request carries all-zero fields.
	`AM_IMPLY(a_zero_fail, clk, arst_n, out_valid && !ok, fields_zero)

	// A valid divider is at least one and gives a nonzero frequency.
	`AM_IMPLY(a_ok_range, clk, arst_n, out_valid && ok, (div_whole != '0) && (achieved_freq_q8 != '0))

endmodule

bind pwm_divider_and_wrap_solver pdws_checker u_pdws_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM divider and wrap solver testbench
// Drives clock and frequency requests with random idle bursts, predicts the
// period, the fractional divider and the achieved frequency with exact
// integer arithmetic, and compares every result beat with the oldest
// prediction while the output side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import pdws_pkg::*;

	typedef struct packed {
		logic [CLK_W-1:0] src_hz;
		logic [FRQ_W-1:0] freq_hz;
	} request_t;

	typedef struct packed {
		logic               ok;
		logic [TOP_W-1:0]   top;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [ACH_W-1:0]   ach;
	} solution_t;

	localparam int LATENCY = 75;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM = 1800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CLK_W-1:0] source_clock = '0;
	logic [FRQ_W-1:0] wanted_freq = '0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid, ok;
	logic [TOP_W-1:0] counter_top;
	logic [WHOLE_W-1:0] div_whole;
	logic [FRAC_W-1:0] div_sixteenths;
	logic [ACH_W-1:0] achieved_freq_q8;

	request_t pending_requests[$];
	solution_t expected_solutions[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stimulus_loaded = 1'b0;
	bit calm_tail = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	pwm_divider_and_wrap_solver uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source_clock(source_clock), .wanted_freq(wanted_freq),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .counter_top(counter_top), .div_whole(div_whole),
		.div_sixteenths(div_sixteenths), .achieved_freq_q8(achieved_freq_q8)
	);

	always #5 clk = ~clk;

	// Exact solution of the period, divider and achieved frequency for one request.
	function automatic solution_t solve_divider(request_t r);
		logic [63:0] c, f, per, den, d16, fden, ach;
		solution_t s;
		s = '0;
		c = 64'(r.src_hz);
		f = 64'(r.freq_hz);
		if (c == 0 || f == 0 || f > c)
			return s;
		per = (c <= 64'd65536 * f) ? c / f : 64'd65536;
		den = f * per;
		d16 = (64'd32 * c + den) / (64'd2 * den);
		if (d16 < 16 || d16 > 4095)
			return s;
		fden = d16 * per;
		ach = (64'd8192 * c + fden) / (64'd2 * fden);
		s.ok = 1'b1;
		s.top = TOP_W'(per - 1);
		s.whole = WHOLE_W'(d16 >> 4);
		s.frac = FRAC_W'(d16);
		s.ach = ACH_W'(ach);
		return s;
	endfunction

	function automatic void add_request(logic [31:0] c, logic [31:0] f);
		request_t r;
		r.src_hz = c;
		r.freq_hz = f;
		pending_requests.push_back(r);
	endfunction

	// Random request, mostly solvable ones with a spread of periods.
	function automatic void add_random_request();
		logic [31:0] c, f;
		int kind;
		kind = $urandom_range(0, 9);
		c = $urandom;
		case (kind)
			0: f = $urandom;
			1: begin
				c = $urandom_range(1, 100000);
				f = $urandom_range(1, 200);
			end
			2: f = 32'($urandom_range(1, 16)) * (c >> 16) + 32'($urandom_range(0, 3));
			3: f = c >> $urandom_range(0, 31);
			4: f = (c >> 16) / 32'($urandom_range(1, 300)) + 32'($urandom_range(0, 2));
			default: f = 32'($urandom_range(1, 2000)) + (c >> $urandom_range(1, 24));
		endcase
		add_request(c, f);
	endfunction

	// Input driver.
	always @(posedge clk) begin
		if (arst_n && stimulus_loaded) begin
			if (in_valid && !in_stall) begin
				expected_solutions.push_back(solve_divider({source_clock, wanted_freq}));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm_tail && $urandom_range(0, 19) == 0) begin
					send_gap <= $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					request_t r;
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					source_clock <= r.src_hz;
					wanted_freq <= r.freq_hz;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and output stall bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_solutions.size() == 0) begin
					$display("%0t: unexpected result beat, ok=%0b top=%0d", $time, ok,
						counter_top);
					errors <= errors + 1;
				end else begin
					solution_t e;
					e = expected_solutions.pop_front();
					if (e !== {ok, counter_top, div_whole, div_sixteenths, achieved_freq_q8}) begin
						$display("%0t: mismatch expected ok=%0b top=%0d whole=%0d frac=%0d ach=%0d",
							$time, e.ok, e.top, e.whole, e.frac, e.ach);
						$display("%0t: mismatch actual   ok=%0b top=%0d whole=%0d frac=%0d ach=%0d",
							$time, ok, counter_top, div_whole, div_sixteenths, achieved_freq_q8);
						errors <= errors + 1;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (!calm_tail && $urandom_range(0, 14) == 0) begin
				recv_gap <= $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			// Watchdog on cycles without any accepted beat.
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int i;
		add_request(32'd0, 32'd0);
		add_request(32'd0, 32'd1000);
		add_request(32'd1000, 32'd0);
		add_request(32'd1000, 32'd1001);
		add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(32'hFFFF_FFFF, 32'd1);
		add_request(32'd1, 32'd1);
		add_request(32'd125000000, 32'd1000);
		add_request(32'd125000000, 32'd20000);
		add_request(32'd65536, 32'd1);
		add_request(32'd65537, 32'd1);
		add_request(32'd1048576, 32'd1);
		add_request(32'd16777215, 32'd1);
		add_request(32'd16777216, 32'd1);
		add_request(32'hFFFF_FFFF, 32'd65535);
		add_request(32'hFFFF_FFFF, 32'd65536);
		add_request(32'hFFFF_FFFF, 32'd257);
		add_request(32'hFFFF_FFFF, 32'd256);
		add_request(32'hAAAA_AAAA, 32'h5555_5555);
		add_request(32'h5555_5555, 32'h2AAA_AAAA);
		add_request(32'd3, 32'd2);
		for (i = 0; i < N_RANDOM; i++)
			add_random_request();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		stimulus_loaded = 1'b1;
		while (pending_requests.size() > 200)
			@(posedge clk);
		calm_tail = 1'b1;
		while (pending_requests.size() > 0 || in_valid || expected_solutions.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_solutions.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
